/* src/asm_pkg.sv */
// ---------------------------------------------------------------------------
// asm_pkg: shared definitions for the advertising record service matcher
// Record kinds, service identifiers, register map and reset values.
// ---------------------------------------------------------------------------
package asm_pkg;

  // Configuration port geometry: five registers of up to 64 bits at 8*i.
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_LSB = 3;

  // Register indexes.
  localparam logic [2:0] REG_UUID_LOW    = 3'd0;
  localparam logic [2:0] REG_UUID_HIGH   = 3'd1;
  localparam logic [2:0] REG_LOCAL_ADDR  = 3'd2;
  localparam logic [2:0] REG_NORMAL_MODE = 3'd3;
  localparam logic [2:0] REG_RSSI_FLOOR  = 3'd4;

  // Register reset values.
  localparam logic              NORMAL_MODE_RST = 1'b1;
  localparam logic signed [7:0] RSSI_FLOOR_RST  = -8'sd85;

  // Record kinds that carry service identifiers.
  localparam logic [7:0] KIND_UUID16       = 8'h03;
  localparam logic [7:0] KIND_UUID128_PART = 8'h06;
  localparam logic [7:0] KIND_UUID128_FULL = 8'h07;

  // 16-bit service identifiers, in payload byte order.
  localparam logic [7:0] PEER_SVC_B0 = 8'h6F;
  localparam logic [7:0] PEER_SVC_B1 = 8'hFD;
  localparam logic [7:0] HOT_SVC_B0  = 8'h19;
  localparam logic [7:0] HOT_SVC_B1  = 8'hC0;

  // Byte offsets within a record (offset 1 is the kind byte).
  localparam logic [7:0] OFS_KIND      = 8'd1;
  localparam logic [7:0] OFS_DATA0     = 8'd2;
  localparam logic [7:0] OFS_DATA1     = 8'd3;
  localparam logic [7:0] OFS_UUID_LAST = 8'd17;

  // Position from which bytes are no longer parsed.
  localparam logic [7:0] POS_LIMIT = 8'hFF;

  // Match codes.
  localparam logic [1:0] CODE_NONE    = 2'd0;
  localparam logic [1:0] CODE_PEER    = 2'd1;
  localparam logic [1:0] CODE_HOTSPOT = 2'd2;

endpackage

/* src/asm_in_if.sv */
// ---------------------------------------------------------------------------
// asm_in_if: input byte channel
// Valid/ready channel carrying one advertising payload byte per transaction.
// ---------------------------------------------------------------------------
interface asm_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic signed [7:0] rssi;
  logic [47:0]       peer_addr;

  modport source (output valid, output data_byte, output last_byte, output rssi,
                  output peer_addr, input ready);
  modport sink (input valid, input data_byte, input last_byte, input rssi,
                input peer_addr, output ready);
endinterface

/* src/asm_out_if.sv */
// ---------------------------------------------------------------------------
// asm_out_if: match result channel
// Valid/ready channel carrying one match result per packet.
// ---------------------------------------------------------------------------
interface asm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] match_code;
  logic       hotspot_seen;

  modport source (output valid, output match_code, output hotspot_seen, input ready);
  modport sink (input valid, input match_code, input hotspot_seen, output ready);
endinterface

/* src/adv_record_service_matcher.sv */
// ---------------------------------------------------------------------------
// adv_record_service_matcher: advertising record service matcher
// Walks the length/kind records of a streamed advertising packet and reports
// one match code and hotspot flag per packet.
// ---------------------------------------------------------------------------
// The block takes one payload byte per clock cycle, back to back, with no
// gaps needed between bytes or packets. Each byte updates the record parser
// in the cycle it is accepted; the result of a packet is registered into the
// output stage as its last byte is accepted. Results leave through a two-entry
// output stage (output register plus skid register), so input bytes keep
// flowing while one result waits to be taken; input stalls only when both
// entries hold results. Configuration is to be written by the user through
// the APB port while the block is idle (not enforced); registers sit at byte address 8*i.
module adv_record_service_matcher (
  input  logic                              clk,
  input  logic                              rst_n,
  asm_in_if.sink                            in_chan,
  asm_out_if.source                         out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [asm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [asm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [asm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import asm_pkg::*;

  // Configuration registers.
  logic [63:0]       uuid_low_r;
  logic [63:0]       uuid_high_r;
  logic [47:0]       local_addr_r;
  logic              normal_mode_r;
  logic signed [7:0] rssi_floor_r;

  // Parser state.
  logic [7:0] next_record_start_r, next_record_start_nxt;
  logic [7:0] byte_position_r, byte_position_nxt;
  logic [7:0] record_offset_r, record_offset_nxt;
  logic [7:0] record_kind_r, record_kind_nxt;
  logic [7:0] first_uuid_byte_r, first_uuid_byte_nxt;
  logic       uuid_equal_so_far_r, uuid_equal_so_far_nxt;
  logic [1:0] running_code_r, running_code_nxt;
  logic       hotspot_flag_r, hotspot_flag_nxt;

  // Output stage.
  logic       out_valid_r;
  logic [1:0] out_code_r;
  logic       out_hot_r;
  logic       skid_valid_r;
  logic [1:0] skid_code_r;
  logic       skid_hot_r;

  logic             in_ready;
  logic             in_acc;
  logic             push;
  logic             pop;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic [127:0]     uuid128;
  logic             rule_code;
  logic [1:0]       res_code;
  logic             res_hot;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];

  assign in_ready      = !skid_valid_r;
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;
  assign push          = in_acc && in_chan.last_byte;
  assign pop           = out_valid_r && out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.match_code   = out_code_r;
  assign out_chan.hotspot_seen = out_hot_r;

  assign uuid128   = {uuid_high_r, uuid_low_r};
  // In calibration mode every candidate record is accepted.
  assign rule_code = !normal_mode_r || (local_addr_r[31:0] < in_chan.peer_addr[31:0]);

  // Register read back.
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_UUID_LOW:    prdata = uuid_low_r;
      REG_UUID_HIGH:   prdata = uuid_high_r;
      REG_LOCAL_ADDR:  prdata = {16'd0, local_addr_r};
      REG_NORMAL_MODE: prdata = {63'd0, normal_mode_r};
      REG_RSSI_FLOOR:  prdata = {56'd0, rssi_floor_r};
      default:         prdata = '0;
    endcase
  end

  // Per-byte record parser.
  always_comb begin
    logic [7:0] b;
    logic [8:0] rec_end;
    logic [7:0] off_inc;
    logic [3:0] uidx;
    logic       eq_new;

    b       = in_chan.data_byte;
    rec_end = {1'b0, byte_position_r} + {1'b0, b} + 9'd1;
    off_inc = (record_offset_r != POS_LIMIT) ? record_offset_r + 8'd1 : record_offset_r;
    uidx    = off_inc[3:0] - OFS_DATA0[3:0];
    eq_new  = uuid_equal_so_far_r && (b == uuid128[{uidx, 3'b000} +: 8]);

    next_record_start_nxt = next_record_start_r;
    byte_position_nxt     = byte_position_r;
    record_offset_nxt     = record_offset_r;
    record_kind_nxt       = record_kind_r;
    first_uuid_byte_nxt   = first_uuid_byte_r;
    uuid_equal_so_far_nxt = uuid_equal_so_far_r;
    running_code_nxt      = running_code_r;
    hotspot_flag_nxt      = hotspot_flag_r;

    if (in_acc && (byte_position_r != POS_LIMIT)) begin
      if (byte_position_r == next_record_start_r) begin
        // Length byte: opens a new record.
        next_record_start_nxt = rec_end[8] ? POS_LIMIT : rec_end[7:0];
        record_offset_nxt     = '0;
        record_kind_nxt       = '0;
        uuid_equal_so_far_nxt = 1'b1;
      end else begin
        record_offset_nxt = off_inc;
        if (off_inc == OFS_KIND) begin
          record_kind_nxt = b;
        end else if (record_kind_r == KIND_UUID16) begin
          if (off_inc == OFS_DATA0) begin
            first_uuid_byte_nxt = b;
          end else if (off_inc == OFS_DATA1) begin
            if (first_uuid_byte_r == PEER_SVC_B0 && b == PEER_SVC_B1) begin
              running_code_nxt = rule_code ? CODE_PEER : CODE_NONE;
            end
            if (first_uuid_byte_r == HOT_SVC_B0 && b == HOT_SVC_B1) begin
              running_code_nxt = CODE_HOTSPOT;
              hotspot_flag_nxt = 1'b1;
            end
          end
        end else if (record_kind_r == KIND_UUID128_PART ||
                     record_kind_r == KIND_UUID128_FULL) begin
          if (off_inc >= OFS_DATA0 && off_inc <= OFS_UUID_LAST) begin
            uuid_equal_so_far_nxt = eq_new;
            if (off_inc == OFS_UUID_LAST && eq_new) begin
              running_code_nxt = rule_code ? CODE_PEER : CODE_NONE;
            end
          end
        end
      end
      byte_position_nxt = byte_position_r + 8'd1;
    end

    // A weak packet reports nothing.
    if (in_chan.rssi < rssi_floor_r) begin
      res_code = CODE_NONE;
      res_hot  = 1'b0;
    end else begin
      res_code = running_code_nxt;
      res_hot  = hotspot_flag_nxt;
    end

    if (push) begin
      next_record_start_nxt = '0;
      byte_position_nxt     = '0;
      record_offset_nxt     = '0;
      record_kind_nxt       = '0;
      first_uuid_byte_nxt   = '0;
      uuid_equal_so_far_nxt = 1'b1;
      running_code_nxt      = CODE_NONE;
      hotspot_flag_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_low_r    <= '0;
      uuid_high_r   <= '0;
      local_addr_r  <= '0;
      normal_mode_r <= NORMAL_MODE_RST;
      rssi_floor_r  <= RSSI_FLOOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_UUID_LOW:    uuid_low_r    <= pwdata;
        REG_UUID_HIGH:   uuid_high_r   <= pwdata;
        REG_LOCAL_ADDR:  local_addr_r  <= pwdata[47:0];
        REG_NORMAL_MODE: normal_mode_r <= pwdata[0];
        REG_RSSI_FLOOR:  rssi_floor_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_record_start_r <= '0;
      byte_position_r     <= '0;
      record_offset_r     <= '0;
      record_kind_r       <= '0;
      first_uuid_byte_r   <= '0;
      uuid_equal_so_far_r <= 1'b1;
      running_code_r      <= CODE_NONE;
      hotspot_flag_r      <= 1'b0;
    end else begin
      next_record_start_r <= next_record_start_nxt;
      byte_position_r     <= byte_position_nxt;
      record_offset_r     <= record_offset_nxt;
      record_kind_r       <= record_kind_nxt;
      first_uuid_byte_r   <= first_uuid_byte_nxt;
      uuid_equal_so_far_r <= uuid_equal_so_far_nxt;
      running_code_r      <= running_code_nxt;
      hotspot_flag_r      <= hotspot_flag_nxt;
    end
  end

  // Two-entry output stage; the skid entry only fills while the output
  // register is held by the sink.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_code_r <= skid_code_r;
        out_hot_r  <= skid_hot_r;
      end else if (push) begin
        out_code_r <= res_code;
        out_hot_r  <= res_hot;
      end
    end else if (push) begin
      skid_code_r <= res_code;
      skid_hot_r  <= res_hot;
    end
  end

`ifndef ASSERT_OFF
  // The skid entry is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A result arriving while the output is held must land in the skid entry.
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_chan.ready) |=> skid_valid_r)
    else $error("result lost while output stalled");

  // The end of a packet clears the parser.
  a_packet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (byte_position_r == '0 && running_code_r == CODE_NONE && !hotspot_flag_r))
    else $error("parser state not cleared after last byte");

  // The parser never runs past the start of the next record.
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    byte_position_r <= next_record_start_r)
    else $error("byte position passed next record start");
`endif

endmodule
